### sv/ocs_pkg.sv
// ocs_pkg: types, codes and constants for the overspeed chime sequencer.
// Used by ocs_fsm and overspeed_chime_sequencer_core; no dependencies.
package ocs_pkg;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_BEEP  = 4'b0010,
		PH_PAUSE = 4'b0100,
		PH_HOLD  = 4'b1000
	} phase_t;

	localparam logic [1:0] PHASE_CODE_IDLE  = 2'd0;
	localparam logic [1:0] PHASE_CODE_BEEP  = 2'd1;
	localparam logic [1:0] PHASE_CODE_PAUSE = 2'd2;
	localparam logic [1:0] PHASE_CODE_HOLD  = 2'd3;

	localparam logic [1:0] CFG_SPEED_LIMIT   = 2'd0;
	localparam logic [1:0] CFG_CHIME_ON_TIME = 2'd1;
	localparam logic [1:0] CFG_BASE_INTERVAL = 2'd2;
	localparam logic [1:0] CFG_STARTUP_HOLD  = 2'd3;

	localparam logic [7:0]  RST_SPEED_LIMIT   = 8'd90;
	localparam logic [15:0] RST_CHIME_ON_TIME = 16'd500;
	localparam logic [15:0] RST_BASE_INTERVAL = 16'd5000;
	localparam logic [15:0] RST_STARTUP_HOLD  = 16'd3000;

	localparam logic [15:0] PAUSE_FLOOR_MS = 16'd500;
	localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  speed_limit;
		logic [15:0] chime_on_time;
		logic [15:0] base_interval;
		logic [15:0] startup_hold;
	} ocs_cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] elapsed;
		logic        chime;
	} ocs_state_t;

	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_IDLE:  code = PHASE_CODE_IDLE;
			PH_BEEP:  code = PHASE_CODE_BEEP;
			PH_PAUSE: code = PHASE_CODE_PAUSE;
			default:  code = PHASE_CODE_HOLD;
		endcase
		return code;
	endfunction

endpackage

### sv/ocs_fsm.sv
// ocs_fsm: next-state logic for one tick of the chime sequencer.
// Depends on ocs_pkg.
module ocs_fsm (
	input  ocs_pkg::ocs_cfg_t   cfg,
	input  ocs_pkg::ocs_state_t cur,
	input  logic [7:0]          time_step,
	input  logic [7:0]          vehicle_speed,
	output ocs_pkg::ocs_state_t nxt
);
	import ocs_pkg::*;

	logic [16:0] sum;
	logic [15:0] timer;
	logic        over;
	logic [7:0]  diff;
	logic [15:0] shorten;
	logic [15:0] floor_thr;
	logic [15:0] pause_len;

	assign sum   = {1'b0, cur.elapsed} + {9'b0, time_step};
	assign timer = sum[16] ? TIMER_MAX : sum[15:0];
	assign over  = vehicle_speed > cfg.speed_limit;

	assign diff      = over ? (vehicle_speed - cfg.speed_limit) : (cfg.speed_limit - vehicle_speed);
	// diff * 10
	assign shorten   = {5'b0, diff, 3'b0} + {7'b0, diff, 1'b0};
	assign floor_thr = shorten + PAUSE_FLOOR_MS;
	assign pause_len = (cfg.base_interval < floor_thr) ? PAUSE_FLOOR_MS
	                                                    : (cfg.base_interval - shorten);

	always_comb begin
		nxt         = cur;
		nxt.elapsed = timer;
		unique case (cur.phase)
			PH_IDLE: begin
				nxt.elapsed = '0;
				if (over) begin
					nxt.phase = PH_BEEP;
					nxt.chime = 1'b1;
				end
			end
			PH_BEEP: begin
				if (timer >= cfg.chime_on_time) begin
					nxt.elapsed = '0;
					nxt.phase   = PH_PAUSE;
					nxt.chime   = 1'b0;
				end
			end
			PH_PAUSE: begin
				if (timer >= pause_len) begin
					nxt.elapsed = '0;
					if (over) begin
						nxt.phase = PH_BEEP;
						nxt.chime = 1'b1;
					end else begin
						nxt.phase = PH_IDLE;
					end
				end
			end
			PH_HOLD: begin
				if (timer >= cfg.startup_hold) begin
					nxt.elapsed = '0;
					nxt.phase   = PH_IDLE;
				end
			end
			default: begin
				nxt.phase = PH_HOLD;
			end
		endcase
	end

endmodule

### sv/overspeed_chime_sequencer_core.sv
// overspeed_chime_sequencer_core: top level of the overspeed chime sequencer.
// Depends on ocs_pkg and ocs_fsm.
//
// One tick beat in gives one result beat out. A tick is taken into an input
// register; when the output register is free, the phase and timer update as
// the chime level and phase land in it. A new tick can be taken every cycle
// unless a stalled result holds it off. The only loop is the phase/timer
// update through ocs_fsm and state_q. Register writes apply from the next
// tick on and are to be made while no tick is in flight.
module overspeed_chime_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  time_step,
	input  logic [7:0]  vehicle_speed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        chime_on,
	output logic [1:0]  phase
);
	import ocs_pkg::*;

	ocs_cfg_t   cfg_q;
	ocs_state_t state_q;
	ocs_state_t state_nxt;

	logic       valid_s1;
	logic [7:0] time_step_s1;
	logic [7:0] speed_s1;
	logic       out_valid_q;
	logic       chime_on_q;
	logic [1:0] phase_q;
	logic       out_free;
	logic       adv_s1;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_limit   <= RST_SPEED_LIMIT;
			cfg_q.chime_on_time <= RST_CHIME_ON_TIME;
			cfg_q.base_interval <= RST_BASE_INTERVAL;
			cfg_q.startup_hold  <= RST_STARTUP_HOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SPEED_LIMIT:   cfg_q.speed_limit   <= cfg_data[7:0];
				CFG_CHIME_ON_TIME: cfg_q.chime_on_time <= cfg_data;
				CFG_BASE_INTERVAL: cfg_q.base_interval <= cfg_data;
				CFG_STARTUP_HOLD:  cfg_q.startup_hold  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			time_step_s1 <= time_step;
			speed_s1     <= vehicle_speed;
		end
	end

	ocs_fsm u_fsm (
		.cfg           (cfg_q),
		.cur           (state_q),
		.time_step     (time_step_s1),
		.vehicle_speed (speed_s1),
		.nxt           (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= PH_HOLD;
			state_q.elapsed <= '0;
			state_q.chime   <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chime_on_q <= state_nxt.chime;
			phase_q    <= phase_code(state_nxt.phase);
		end
	end

	assign out_valid = out_valid_q;
	assign chime_on  = chime_on_q;
	assign phase     = phase_q;

endmodule

### verif/tb_overspeed_chime_sequencer_core.sv
// tb_overspeed_chime_sequencer_core: self-checking bench for the overspeed chime sequencer.
// Predicts chime level and phase per tick beat; directed then randomised traffic with stalls.
// Depends on ocs_pkg and overspeed_chime_sequencer_core.
`timescale 1ns / 100ps

module tb_overspeed_chime_sequencer_core;
	import ocs_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int RESET_CYCLES     = 12;
	localparam int SETTLE_CYCLES    = 4;
	localparam int WATCHDOG_CYCLES  = 1000;
	localparam int SHORTEN_PER_KMH  = 10;
	localparam int MAX_REPORTS      = 10;

	typedef struct {
		logic       chime;
		logic [1:0] phase;
	} chime_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  time_step;
	logic [7:0]  vehicle_speed;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        chime_on;
	logic [1:0]  phase;

	// predictor state and register copies
	logic [7:0]  lim_model;
	logic [15:0] on_time_model;
	logic [15:0] base_model;
	logic [15:0] hold_model;
	logic [1:0]  phase_model;
	logic [15:0] elapsed_model;
	logic        chime_model;

	chime_beat_t pending_chime_beats[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatches    = 0;
	int unsigned ticks_sent    = 0;
	int unsigned beats_checked = 0;
	int unsigned cfg_writes    = 0;
	int unsigned beeps_started = 0;
	int unsigned idle_returns  = 0;

	overspeed_chime_sequencer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.time_step     (time_step),
		.vehicle_speed (vehicle_speed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chime_on      (chime_on),
		.phase         (phase)
	);

	always #CLK_HALF clk = ~clk;

	function automatic int pause_ms(input logic [7:0] speed);
		int diff;
		int len;
		diff = int'(lim_model) - int'(speed);
		if (diff < 0) diff = -diff;
		len = int'(base_model) - diff * SHORTEN_PER_KMH;
		if (len < int'(PAUSE_FLOOR_MS)) len = int'(PAUSE_FLOOR_MS);
		return len;
	endfunction

	task automatic advance_chime_state(input logic [7:0] tick_ms, input logic [7:0] speed);
		int unsigned sum;
		logic        over;
		over = speed > lim_model;
		sum  = int'(elapsed_model) + int'(tick_ms);
		if (sum > int'(TIMER_MAX)) sum = int'(TIMER_MAX);
		elapsed_model = sum[15:0];
		case (phase_model)
			PHASE_CODE_IDLE: begin
				elapsed_model = 16'd0;
				if (over) begin
					phase_model = PHASE_CODE_BEEP;
					chime_model = 1'b1;
					beeps_started++;
				end
			end
			PHASE_CODE_BEEP: begin
				if (elapsed_model >= on_time_model) begin
					elapsed_model = 16'd0;
					phase_model   = PHASE_CODE_PAUSE;
					chime_model   = 1'b0;
				end
			end
			PHASE_CODE_PAUSE: begin
				if (int'(elapsed_model) >= pause_ms(speed)) begin
					elapsed_model = 16'd0;
					if (over) begin
						phase_model = PHASE_CODE_BEEP;
						chime_model = 1'b1;
						beeps_started++;
					end else begin
						phase_model = PHASE_CODE_IDLE;
						idle_returns++;
					end
				end
			end
			default: begin
				if (elapsed_model >= hold_model) begin
					elapsed_model = 16'd0;
					phase_model   = PHASE_CODE_IDLE;
				end
			end
		endcase
		pending_chime_beats.push_back('{chime: chime_model, phase: phase_model});
	endtask

	task automatic send_tick(input logic [7:0] tick_ms, input logic [7:0] speed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		time_step     <= tick_ms;
		vehicle_speed <= speed;
		do @(posedge clk); while (in_stall !== 1'b0);
		ticks_sent++;
		advance_chime_state(tick_ms, speed);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_chime_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_SPEED_LIMIT:   lim_model     = data[7:0];
			CFG_CHIME_ON_TIME: on_time_model = data;
			CFG_BASE_INTERVAL: base_model    = data;
			default:           hold_model    = data;
		endcase
	endtask

	function automatic logic [15:0] pick_duration();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) return 16'd0;
		if (r < 13) return 16'hFFFF;
		if (r < 75) return 16'($urandom_range(1500));
		return 16'($urandom_range(6000));
	endfunction

	// zero hold ends on the first tick; speed equal to the limit is not over it
	task automatic test_zero_hold();
		write_reg(CFG_STARTUP_HOLD, 16'd0);
		send_tick(8'd0, 8'd0);
		send_tick(8'd255, 8'd90);
		send_tick(8'd255, 8'd91);
	endtask

	task automatic test_default_beep();
		send_tick(8'd255, 8'd91);
		send_tick(8'd244, 8'd91);
		send_tick(8'd1, 8'd91);
		repeat (17) send_tick(8'd255, 8'd0);
	endtask

	task automatic test_pause_floor();
		write_reg(CFG_SPEED_LIMIT, 16'd100);
		write_reg(CFG_CHIME_ON_TIME, 16'd0);
		write_reg(CFG_BASE_INTERVAL, 16'd1000);
		send_tick(8'd10, 8'd150);
		send_tick(8'd0, 8'd150);
		send_tick(8'd250, 8'd150);
		send_tick(8'd249, 8'd150);
		send_tick(8'd1, 8'd150);
		send_tick(8'd0, 8'd149);
		send_tick(8'd255, 8'd149);
		send_tick(8'd254, 8'd149);
		send_tick(8'd1, 8'd149);
		send_tick(8'd0, 8'd100);
		repeat (3) send_tick(8'd255, 8'd100);
		send_tick(8'd235, 8'd100);
		// base interval under the floor
		write_reg(CFG_BASE_INTERVAL, 16'd100);
		send_tick(8'd0, 8'd101);
		send_tick(8'd0, 8'd101);
		send_tick(8'd255, 8'd101);
		send_tick(8'd245, 8'd101);
	endtask

	task automatic test_limit_extremes();
		write_reg(CFG_SPEED_LIMIT, 16'hFFFF);
		send_tick(8'd0, 8'd255);
		send_tick(8'd255, 8'd255);
		send_tick(8'd255, 8'd255);
		send_tick(8'd255, 8'd255);
		write_reg(CFG_SPEED_LIMIT, 16'hFF00);
		send_tick(8'd0, 8'd0);
		send_tick(8'd0, 8'd1);
	endtask

	// timer must clamp at full scale rather than wrap, or the beep never ends
	task automatic test_timer_saturation();
		write_reg(CFG_BASE_INTERVAL, 16'hFFFF);
		write_reg(CFG_CHIME_ON_TIME, 16'hFFFF);
		repeat (256) send_tick(8'd255, 8'($urandom_range(255)));
		send_tick(8'd1, 8'($urandom_range(255)));
		send_tick(8'd255, 8'($urandom_range(255)));
		write_reg(CFG_BASE_INTERVAL, 16'd0);
		send_tick(8'd255, 8'd0);
		send_tick(8'd255, 8'd0);
		write_reg(CFG_STARTUP_HOLD, 16'hFFFF);
	endtask

	task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned segments, input int unsigned ticks_per_seg);
		logic [7:0]  lim;
		logic [7:0]  tick_ms;
		int          s;
		int unsigned r;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int seg = 0; seg < segments; seg++) begin
			r = $urandom_range(9);
			lim = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(255));
			write_reg(CFG_SPEED_LIMIT, {8'($urandom_range(255)), lim});
			write_reg(CFG_CHIME_ON_TIME, pick_duration());
			write_reg(CFG_BASE_INTERVAL, pick_duration());
			if ($urandom_range(3) == 0) write_reg(CFG_STARTUP_HOLD, 16'($urandom));
			for (int i = 0; i < ticks_per_seg; i++) begin
				if ($urandom_range(99) < 70) begin
					s = int'(lim) + int'($urandom_range(24)) - 12;
					if (s < 0) s = 0;
					if (s > 255) s = 255;
				end else begin
					s = $urandom_range(255);
				end
				r = $urandom_range(99);
				if (r < 55) tick_ms = 8'($urandom_range(255));
				else if (r < 90) tick_ms = 8'($urandom_range(40));
				else tick_ms = (r < 95) ? 8'd0 : 8'd255;
				send_tick(tick_ms, 8'(s));
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		chime_beat_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_chime_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result beat: chime_on=%b phase=%0d", chime_on, phase);
			end else begin
				want = pending_chime_beats.pop_front();
				beats_checked++;
				if (chime_on !== want.chime || phase !== want.phase) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result beat %0d: expected chime_on=%b phase=%0d, got chime_on=%b phase=%0d",
							beats_checked, want.chime, want.phase, chime_on, phase);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_overspeed_chime_sequencer_core: FAIL");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= CFG_SPEED_LIMIT;
		cfg_data      <= 16'd0;
		in_valid      <= 1'b0;
		time_step     <= 8'd0;
		vehicle_speed <= 8'd0;
		lim_model     = RST_SPEED_LIMIT;
		on_time_model = RST_CHIME_ON_TIME;
		base_model    = RST_BASE_INTERVAL;
		hold_model    = RST_STARTUP_HOLD;
		phase_model   = PHASE_CODE_HOLD;
		elapsed_model = 16'd0;
		chime_model   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 79;
		test_zero_hold();
		test_default_beep();
		test_pause_floor();
		test_limit_extremes();
		test_timer_saturation();
		test_random_traffic(20, 79, 4, 50);
		test_random_traffic(79, 20, 4, 50);
		test_random_traffic(0, 0, 4, 50);
		wait_for_results();

		$display("covered %0d tick beats, %0d result beats compared, %0d register writes",
			ticks_sent, beats_checked, cfg_writes);
		$display("%0d beeps started, %0d pauses back to idle, %0d mismatches",
			beeps_started, idle_returns, mismatches);
		if (mismatches == 0)
			$display("tb_overspeed_chime_sequencer_core: PASS");
		else
			$display("tb_overspeed_chime_sequencer_core: FAIL");
		$finish;
	end

endmodule

### overspeed_chime_sequencer_core.f
sv/ocs_pkg.sv
sv/ocs_fsm.sv
sv/overspeed_chime_sequencer_core.sv
verif/tb_overspeed_chime_sequencer_core.sv
